// ===== hdl/windowed_mean_std_dev_core_defines.svh =====
// Assertion macros for the windowed mean and deviation core.
// No dependencies.
`ifndef WINDOWED_MEAN_STD_DEV_CORE_DEFINES_SVH
`define WINDOWED_MEAN_STD_DEV_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define WMS_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define WMS_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define WMS_ASSERT_IMP(label, clk, rst, a, c)
`define WMS_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

// ===== hdl/wmsd_pkg.sv =====
// Shared constants and types for the windowed mean and deviation core.
// No dependencies.
`timescale 1ns / 1ps
package wmsd_pkg;
   localparam int MaxWindow = 256;
   localparam int SampleBits = 16;
   localparam int IdxBits = $clog2(MaxWindow);
   localparam int LenBits = IdxBits + 1;
   localparam int SumBits = SampleBits + IdxBits;
   localparam int SqBits = 2 * SampleBits + IdxBits;
   localparam int NumBits = SqBits + LenBits;
   localparam int LsqBits = 2 * LenBits;
   localparam int RootBits = SampleBits;
   localparam int RadBits = 2 * RootBits;
   localparam logic [1:0] CMD_ADD = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;
   typedef struct packed {
      logic [SampleBits-1:0] mean_value;
      logic [SampleBits-1:0] std_value;
   } stats_type;
endpackage

// ===== hdl/windowed_mean_std_dev_core.sv =====
// Top level of the windowed mean and deviation core.
// Depends on wmsd_pkg, wmsd_divider, wmsd_sqrt and the defines header.
`timescale 1ns / 1ps
// Each command raises busy and ends with one rsp_strobe word that the receiver
// must take in that cycle. A new command may be taken in the strobe cycle.
// A clear first sweeps all MaxWindow (256) entries of the sample memory, then
// divides for the percent. After reset the same sweep runs before the
// first word is taken. One shared divider serves every division. A plain add,
// an unused code, a frozen query or a stop-mode query only divide for the
// percent. A running query walks the window once through the registered
// memory read, then divides for the mean and the variance, takes the square
// root and divides for the percent. An add that freezes the window runs the
// same sequence.
`include "windowed_mean_std_dev_core_defines.svh"
module windowed_mean_std_dev_core (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [1:0] req_cmd,
   input  logic [15:0] req_sample,
   output logic rsp_strobe,
   output logic [15:0] rsp_mean_value,
   output logic [15:0] rsp_std_value,
   output logic rsp_stats_valid,
   output logic rsp_is_complete,
   output logic [6:0] rsp_progress_percent,
   output logic [7:0] rsp_fill_position,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [2:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   import wmsd_pkg::*;
   localparam logic [3:0] ST_CLEAR = 4'd0, ST_IDLE = 4'd1, ST_ADD = 4'd2,
      ST_WALK = 4'd3, ST_MDIV = 4'd4, ST_VDIV = 4'd5, ST_SQRT = 4'd6,
      ST_PDIV = 4'd7, ST_OUT = 4'd8, ST_MWAIT = 4'd9, ST_VWAIT = 4'd10,
      ST_SWAIT = 4'd11, ST_PWAIT = 4'd12;
   localparam logic [2:0] ADDR_LEN = 3'd0, ADDR_STOP = 3'd4;

   logic [SampleBits-1:0] mem [MaxWindow];
   logic [SampleBits-1:0] rd_data_ff;
   logic [3:0] state_ff;
   logic [8:0] len_ff;
   logic stop_ff, frozen_ff, valid_ff, is_query_ff;
   logic [IdxBits-1:0] widx_ff;
   logic [LenBits-1:0] cnt_ff;
   logic rd_valid_ff;
   logic [SumBits-1:0] sum_ff;
   logic [SqBits-1:0] sq_ff;
   stats_type held_ff, out_ff;
   logic [1:0] cmd_ff;
   logic [SampleBits-1:0] samp_ff;
   logic [LenBits-1:0] n;
   logic [IdxBits-1:0] pos;
   logic wr_en;
   logic [IdxBits-1:0] wr_addr;
   logic [SampleBits-1:0] wr_data;
   logic div_start, div_done, sq_start, sq_done;
   logic [NumBits-1:0] div_a, div_q;
   logic [LsqBits-1:0] div_b;
   logic [RootBits-1:0] root;
   logic [NumBits-1:0] num;
   logic accept;
   logic strobe_ff;
   logic [6:0] pct_ff;

   assign n = (len_ff == 9'd0) ? LenBits'(1) :
              (len_ff > 9'(MaxWindow)) ? LenBits'(MaxWindow) : LenBits'(len_ff);
   assign pos = ({1'b0, widx_ff} < n) ? widx_ff : '0;
   assign accept = start && !busy;
   assign busy = state_ff != ST_IDLE;
   assign pready = 1'b1;
   assign num = NumBits'(sq_ff) * NumBits'(n) - NumBits'(sum_ff) * NumBits'(sum_ff);

   always_comb begin
      prdata = '0;
      case (paddr)
         ADDR_LEN: prdata = 32'(len_ff);
         ADDR_STOP: prdata = 32'(stop_ff);
         default: prdata = '0;
      endcase
   end

   always_comb begin
      wr_en = 1'b0;
      wr_addr = pos;
      wr_data = samp_ff;
      if (state_ff == ST_CLEAR) begin
         wr_en = 1'b1;
         wr_addr = cnt_ff[IdxBits-1:0];
         wr_data = '0;
      end else if (state_ff == ST_ADD && !frozen_ff) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[cnt_ff[IdxBits-1:0]];
   end

   always_comb begin
      div_start = 1'b0;
      div_a = '0;
      div_b = '0;
      case (state_ff)
         ST_MDIV: begin
            div_start = 1'b1;
            div_a = NumBits'(sum_ff);
            div_b = LsqBits'(n);
         end
         ST_VDIV: begin
            div_start = 1'b1;
            div_a = num;
            div_b = LsqBits'(n) * LsqBits'(n);
         end
         ST_PDIV: begin
            div_start = 1'b1;
            div_a = NumBits'(pos) * NumBits'(100);
            div_b = LsqBits'(n);
         end
         default: div_start = 1'b0;
      endcase
   end
   assign sq_start = state_ff == ST_SQRT;

   wmsd_divider u_div (.clock(clock), .reset(reset), .start(div_start),
      .dividend(div_a), .divisor(div_b), .done(div_done), .quotient(div_q));
   wmsd_sqrt u_sqrt (.clock(clock), .reset(reset), .start(sq_start),
      .radicand(div_q), .done(sq_done), .root(root));

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_cmd;
         samp_ff <= req_sample;
      end
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff <= '0;
         len_ff <= 9'(MaxWindow);
         stop_ff <= 1'b1;
         frozen_ff <= 1'b0;
         widx_ff <= '0;
         held_ff <= '0;
         valid_ff <= 1'b0;
         is_query_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= state_ff == ST_OUT;
         if (psel && penable && pwrite) begin
            case (paddr)
               ADDR_LEN: len_ff <= pwdata[8:0];
               ADDR_STOP: stop_ff <= pwdata[0];
               default: len_ff <= len_ff;
            endcase
         end
         case (state_ff)
            ST_CLEAR: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == LenBits'(MaxWindow - 1)) begin
                  state_ff <= is_query_ff ? ST_PDIV : ST_IDLE;
                  is_query_ff <= 1'b0;
               end
            end
            ST_IDLE: begin
               if (accept && req_cmd == CMD_QUERY && frozen_ff) begin
                  out_ff <= held_ff;
                  valid_ff <= 1'b1;
               end else begin
                  valid_ff <= 1'b0;
                  out_ff <= '0;
               end
               if (accept) begin
                  case (req_cmd)
                     CMD_CLEAR: begin
                        frozen_ff <= 1'b0;
                        widx_ff <= '0;
                        cnt_ff <= '0;
                        is_query_ff <= 1'b1;
                        state_ff <= ST_CLEAR;
                     end
                     CMD_QUERY: begin
                        if (frozen_ff) begin
                           state_ff <= ST_PDIV;
                        end else if (!stop_ff) begin
                           cnt_ff <= '0;
                           sum_ff <= '0;
                           sq_ff <= '0;
                           rd_valid_ff <= 1'b0;
                           state_ff <= ST_WALK;
                        end else begin
                           state_ff <= ST_PDIV;
                        end
                     end
                     default: state_ff <= (req_cmd == CMD_ADD) ? ST_ADD : ST_PDIV;
                  endcase
               end
            end
            ST_ADD: begin
               state_ff <= ST_PDIV;
               if (!frozen_ff) begin
                  if ({1'b0, pos} + 1'b1 >= n) begin
                     widx_ff <= '0;
                     if (stop_ff) begin
                        frozen_ff <= 1'b1;
                        cnt_ff <= '0;
                        sum_ff <= '0;
                        sq_ff <= '0;
                        rd_valid_ff <= 1'b0;
                        state_ff <= ST_WALK;
                     end
                  end else begin
                     widx_ff <= pos + 1'b1;
                  end
               end
            end
            ST_WALK: begin
               if (cnt_ff < n) cnt_ff <= cnt_ff + 1'b1;
               rd_valid_ff <= cnt_ff < n;
               if (rd_valid_ff) begin
                  sum_ff <= sum_ff + SumBits'(rd_data_ff);
                  sq_ff <= sq_ff + SqBits'(rd_data_ff) * SqBits'(rd_data_ff);
               end
               if (rd_valid_ff && cnt_ff == n) state_ff <= ST_MDIV;
            end
            ST_MDIV: state_ff <= ST_MWAIT;
            ST_MWAIT: if (div_done) begin
               held_ff.mean_value <= div_q[SampleBits-1:0];
               state_ff <= ST_VDIV;
            end
            ST_VDIV: state_ff <= ST_VWAIT;
            ST_VWAIT: if (div_done) state_ff <= ST_SQRT;
            ST_SQRT: state_ff <= ST_SWAIT;
            ST_SWAIT: if (sq_done) begin
               held_ff.std_value <= root;
               if (cmd_ff == CMD_QUERY) begin
                  out_ff <= '{mean_value: held_ff.mean_value, std_value: root};
                  valid_ff <= 1'b1;
               end
               state_ff <= ST_PDIV;
            end
            ST_PDIV: state_ff <= ST_PWAIT;
            ST_PWAIT: if (div_done) begin
               pct_ff <= div_q[6:0];
               state_ff <= ST_OUT;
            end
            ST_OUT: state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_mean_value = valid_ff ? out_ff.mean_value : '0;
   assign rsp_std_value = valid_ff ? out_ff.std_value : '0;
   assign rsp_stats_valid = valid_ff;
   assign rsp_is_complete = frozen_ff;
   assign rsp_progress_percent = pct_ff;
   assign rsp_fill_position = pos;

   `WMS_ASSERT_IMP(a_strobe_ends, clock, reset, rsp_strobe, !busy)
   `WMS_ASSERT_NXT(a_accept_busy, clock, reset, accept, busy)
   `WMS_ASSERT_IMP(a_pos_in_len, clock, reset, !busy, {1'b0, pos} < n)
endmodule

// ===== hdl/wmsd_divider.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on wmsd_pkg.
`timescale 1ns / 1ps
module wmsd_divider (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [wmsd_pkg::NumBits-1:0] dividend,
   input  logic [wmsd_pkg::LsqBits-1:0] divisor,
   output logic done,
   output logic [wmsd_pkg::NumBits-1:0] quotient
);
   import wmsd_pkg::*;
   localparam int CntBits = $clog2(NumBits + 1);
   logic [NumBits-1:0] quot_ff, quot_in;
   logic [LsqBits:0] rem_ff, rem_in, trial;
   logic [LsqBits-1:0] dvs_ff;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   always_comb begin
      quot_in = quot_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff[LsqBits-1:0], quot_ff[NumBits-1]};
      if (start) begin
         quot_in = dividend;
         rem_in = '0;
         cnt_in = CntBits'(NumBits);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quot_in = {quot_ff[NumBits-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quot_in = {quot_ff[NumBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end
   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      if (start) dvs_ff <= divisor;
      if (reset) begin
         cnt_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end
   assign done = done_ff;
   assign quotient = quot_ff;
endmodule

// ===== hdl/wmsd_sqrt.sv =====
// Digit-by-digit floor square root of the radicand clamped to RadBits, one result bit per cycle.
// Depends on wmsd_pkg.
`timescale 1ns / 1ps
module wmsd_sqrt (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [wmsd_pkg::NumBits-1:0] radicand,
   output logic done,
   output logic [wmsd_pkg::RootBits-1:0] root
);
   import wmsd_pkg::*;
   localparam int CntBits = $clog2(RootBits + 1);
   logic [RadBits-1:0] rad_ff, rad_in;
   logic [RootBits+1:0] rem_ff, rem_in, trial, test;
   logic [RootBits-1:0] root_ff, root_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic big;
   assign big = (radicand >> RadBits) != '0;
   always_comb begin
      rad_in = rad_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff[RootBits-1:0], rad_ff[RadBits-1 -: 2]};
      test = {root_ff, 2'b01};
      if (start) begin
         rad_in = big ? '1 : radicand[RadBits-1:0];
         rem_in = '0;
         root_in = '0;
         cnt_in = CntBits'(RootBits);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RadBits-3:0], 2'b00};
         if (trial >= test) begin
            rem_in = trial - test;
            root_in = {root_ff[RootBits-2:0], 1'b1};
         end else begin
            rem_in = trial;
            root_in = {root_ff[RootBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end
   always_ff @(posedge clock) begin
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      if (reset) begin
         cnt_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end
   assign done = done_ff;
   assign root = root_ff;
endmodule

// ===== dv/windowed_mean_std_dev_core_tb.sv =====
// Self-checking testbench for windowed_mean_std_dev_core: directed and random commands,
// checked word by word against an in-bench predictor of the sample window.
// Depends on wmsd_pkg and the core RTL.
`timescale 1ns / 1ps
module windowed_mean_std_dev_core_tb;
   import wmsd_pkg::*;

   typedef struct {
      logic [1:0] cmd;
      logic [15:0] sample;
   } command_word;

   typedef struct {
      logic [15:0] mean_value;
      logic [15:0] std_value;
      logic stats_valid;
      logic is_complete;
      logic [6:0] progress_percent;
      logic [7:0] fill_position;
   } stats_word;

   localparam int LimitCycles = 4000000;
   localparam logic [2:0] ADDR_LENGTH = 3'd0;
   localparam logic [2:0] ADDR_STOP = 3'd4;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_cmd = CMD_ADD;
   logic [15:0] req_sample = '0;
   logic rsp_strobe;
   logic [15:0] rsp_mean_value;
   logic [15:0] rsp_std_value;
   logic rsp_stats_valid;
   logic rsp_is_complete;
   logic [6:0] rsp_progress_percent;
   logic [7:0] rsp_fill_position;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   windowed_mean_std_dev_core dut (.*);

   always #2 clock = ~clock;

   // predictor state
   logic [15:0] window_store [MaxWindow];
   int unsigned write_pos;
   bit frozen_now;
   logic [15:0] held_mean;
   logic [15:0] held_std;
   logic [8:0] length_reg = 9'd256;
   bit stop_reg = 1'b1;

   command_word command_q[$];
   stats_word expected_stats_q[$];
   int error_count = 0;
   int cycle_count = 0;
   bit taken = 1'b0;
   bit gaps_on = 1'b1;
   int gap_left = 0;

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
      error_count++;
   endtask

   function automatic int unsigned window_len();
      if (length_reg == 0) return 1;
      if (length_reg > MaxWindow) return MaxWindow;
      return length_reg;
   endfunction

   function automatic int unsigned window_pos();
      return (write_pos < window_len()) ? write_pos : 0;
   endfunction

   function automatic logic [63:0] floor_root(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] probe;
      res = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
         if (v >= res + probe) begin
            v -= res + probe;
            res = (res >> 1) + probe;
         end else begin
            res >>= 1;
         end
         probe >>= 2;
      end
      return res;
   endfunction

   function automatic void latch_stats();
      int unsigned n;
      logic [127:0] sum;
      logic [127:0] sq;
      logic [127:0] spread;
      n = window_len();
      sum = 0;
      sq = 0;
      for (int i = 0; i < n; i++) begin
         sum += window_store[i];
         sq += 128'(window_store[i]) * window_store[i];
      end
      held_mean = 16'(sum / n);
      spread = (sq * n - sum * sum) / (128'(n) * n);
      held_std = 16'(floor_root(spread[63:0]));
   endfunction

   function automatic stats_word window_stats_step(command_word w);
      stats_word r;
      int unsigned n;
      int unsigned pos;
      r = '{default: '0};
      case (w.cmd)
         CMD_ADD: begin
            if (!frozen_now) begin
               n = window_len();
               pos = window_pos();
               window_store[pos] = w.sample;
               pos++;
               if (pos >= n) begin
                  if (stop_reg) begin
                     frozen_now = 1'b1;
                     latch_stats();
                  end
                  pos = 0;
               end
               write_pos = pos;
            end
         end
         CMD_CLEAR: begin
            foreach (window_store[i]) window_store[i] = '0;
            frozen_now = 1'b0;
            write_pos = 0;
         end
         CMD_QUERY: begin
            if (frozen_now) begin
               r.stats_valid = 1'b1;
            end else if (!stop_reg) begin
               latch_stats();
               r.stats_valid = 1'b1;
            end
            if (r.stats_valid) begin
               r.mean_value = held_mean;
               r.std_value = held_std;
            end
         end
         default: ;
      endcase
      pos = window_pos();
      r.is_complete = frozen_now;
      r.progress_percent = 7'((100 * pos) / window_len());
      r.fill_position = 8'(pos);
      return r;
   endfunction

   // monitor: check words, record accepted commands, watch the limit
   always @(posedge clock) begin
      stats_word want;
      cycle_count++;
      if (cycle_count > LimitCycles) begin
         $display("timeout");
         $display("windowed_mean_std_dev_core_tb failed");
         $finish;
      end else if (!reset) begin
         if (rsp_strobe) begin
            if (expected_stats_q.size() == 0) begin
               report_mismatch("unexpected word", rsp_fill_position, -1);
            end else begin
               want = expected_stats_q.pop_front();
               if (rsp_mean_value !== want.mean_value)
                  report_mismatch("mean_value", rsp_mean_value, want.mean_value);
               if (rsp_std_value !== want.std_value)
                  report_mismatch("std_value", rsp_std_value, want.std_value);
               if (rsp_stats_valid !== want.stats_valid)
                  report_mismatch("stats_valid", rsp_stats_valid, want.stats_valid);
               if (rsp_is_complete !== want.is_complete)
                  report_mismatch("is_complete", rsp_is_complete, want.is_complete);
               if (rsp_progress_percent !== want.progress_percent)
                  report_mismatch("progress_percent", rsp_progress_percent,
                                  want.progress_percent);
               if (rsp_fill_position !== want.fill_position)
                  report_mismatch("fill_position", rsp_fill_position, want.fill_position);
            end
         end
         if (start && !busy) begin
            taken = 1'b1;
            expected_stats_q.push_back(window_stats_step('{req_cmd, req_sample}));
         end
      end
   end

   // driver: present queued commands, with random gaps while gaps_on is set
   always @(negedge clock) begin
      command_word w;
      bit next_start;
      if (!reset && !(start && !taken)) begin
         next_start = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (command_q.size() > 0) begin
            w = command_q.pop_front();
            req_cmd <= w.cmd;
            req_sample <= w.sample;
            next_start = 1'b1;
            gap_left = gaps_on ? $urandom_range(0, 19) : 0;
         end
         start <= next_start;
      end
      taken = 1'b0;
   end

   task automatic csr_write(logic [2:0] addr, logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == ADDR_LENGTH) length_reg = value[8:0];
      else stop_reg = value[0];
   endtask

   task automatic drain();
      do @(posedge clock);
      while (command_q.size() > 0 || start || expected_stats_q.size() > 0 || busy);
   endtask

   task automatic configure(int unsigned len, bit stop);
      drain();
      csr_write(ADDR_LENGTH, len);
      csr_write(ADDR_STOP, stop);
   endtask

   task automatic push(logic [1:0] cmd, logic [15:0] sample);
      command_q.push_back('{cmd, sample});
   endtask

   function automatic logic [15:0] draw_sample();
      case ($urandom_range(0, 9))
         0: return 16'hFFFF;
         1: return 16'h0000;
         2, 3: return 16'($urandom_range(0, 255));
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic logic [1:0] draw_cmd();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return CMD_ADD;
      if (r < 90) return CMD_QUERY;
      if (r < 95) return CMD_CLEAR;
      return CMD_UNUSED;
   endfunction

   initial begin
      int unsigned len;
      foreach (window_store[i]) window_store[i] = '0;
      write_pos = 0;
      frozen_now = 1'b0;
      held_mean = '0;
      held_std = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values, partial window in stop mode, unused code, clear
      push(CMD_QUERY, 16'h0000);
      push(CMD_ADD, 16'h0000);
      push(CMD_ADD, 16'hFFFF);
      push(CMD_UNUSED, 16'h1234);
      push(CMD_QUERY, 16'h0000);
      push(CMD_CLEAR, 16'hFFFF);
      configure(4, 1'b0);
      // widest spread, then running stats
      push(CMD_ADD, 16'hFFFF);
      push(CMD_ADD, 16'h0000);
      push(CMD_ADD, 16'hFFFF);
      push(CMD_ADD, 16'h0000);
      push(CMD_QUERY, 16'h0000);
      push(CMD_ADD, 16'h0001);
      push(CMD_QUERY, 16'h0000);
      configure(2, 1'b1);
      // freeze, ignored add, latched query
      push(CMD_ADD, 16'h0050);
      push(CMD_ADD, 16'h0070);
      push(CMD_ADD, 16'h0099);
      push(CMD_QUERY, 16'h0000);
      configure(2, 1'b0);
      // still frozen until a clear
      push(CMD_QUERY, 16'h0000);
      push(CMD_CLEAR, 16'h0000);
      push(CMD_QUERY, 16'h0000);
      configure(8, 1'b0);
      for (int i = 0; i < 5; i++) push(CMD_ADD, 16'(i * 16 + 3));
      configure(3, 1'b0);
      // write index beyond the shortened window
      push(CMD_QUERY, 16'h0000);
      push(CMD_ADD, 16'h0011);
      configure(0, 1'b0);
      push(CMD_ADD, 16'h0022);
      push(CMD_QUERY, 16'h0000);
      configure(300, 1'b1);
      push(CMD_QUERY, 16'h0000);
      configure(1, 1'b1);
      push(CMD_ADD, 16'hFFFF);
      push(CMD_QUERY, 16'h0000);

      for (int phase = 0; phase < 16; phase++) begin
         case ($urandom_range(0, 9))
            0: len = 256;
            1: len = $urandom_range(0, 1) ? 0 : $urandom_range(257, 511);
            2: len = 1;
            default: len = $urandom_range(2, 16);
         endcase
         configure(len, 1'($urandom_range(0, 1)));
         gaps_on = (phase % 3) != 1;
         if (phase % 4 == 0) push(CMD_CLEAR, 16'($urandom()));
         for (int i = 0; i < 62; i++) push(draw_cmd(), draw_sample());
      end
      configure(256, 1'b1);

      drain();
      repeat (600) @(posedge clock);
      if (error_count == 0) begin
         $display("windowed_mean_std_dev_core_tb passed");
      end else begin
         $display("windowed_mean_std_dev_core_tb failed");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/wmsd_pkg.sv
hdl/wmsd_divider.sv
hdl/wmsd_sqrt.sv
hdl/windowed_mean_std_dev_core.sv
dv/windowed_mean_std_dev_core_tb.sv
